// ===== src/pmt_pkg.sv =====
// pmt_pkg: shared types, constants and helpers of the point matrix transform
// no dependencies; used by the channel interfaces, the divider and the top level
package pmt_pkg;

  localparam int CoefW      = 16;  // signed q4.12 coefficient
  localparam int CompW      = 32;  // signed q16.16 component
  localparam int ProdW      = CompW + CoefW;
  localparam int SumW       = 51;  // three products plus shifted constant, exact
  localparam int RemW       = SumW + 1;
  localparam int QuotW      = 32;
  localparam int FracW      = 16;
  localparam int DivStages  = 16;
  localparam int BitsPerStg = QuotW / DivStages;
  localparam int RegIdxW    = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_3X3    = 2'd0;
  localparam kind_t KIND_AFFINE = 2'd1;
  localparam kind_t KIND_PROJ   = 2'd2;

  typedef logic [RegIdxW-1:0] reg_idx_t;
  localparam reg_idx_t REG_ROW0 = 3'd0;
  localparam reg_idx_t REG_ROW1 = 3'd1;
  localparam reg_idx_t REG_ROW2 = 3'd2;
  localparam reg_idx_t REG_ROW3 = 3'd3;
  localparam reg_idx_t REG_KIND = 3'd4;

  localparam logic [63:0] ROW0_RST = 64'd4096;
  localparam logic [63:0] ROW1_RST = 64'd268435456;
  localparam logic [63:0] ROW2_RST = 64'd17592186044416;
  localparam logic [63:0] ROW3_RST = 64'd1152921504606846976;

  // per-lane data that rides alongside the divider
  typedef struct packed {
    logic [CompW-1:0] rnd;
    logic             rclip;
    logic             ovf;
    logic             neg;
  } lane_side_t;

  typedef struct packed {
    lane_side_t [2:0] lane;
    logic             use_div;
    logic             wz;
  } side_t;

  function automatic logic signed [CoefW-1:0] coef(input logic [63:0] row, input int k);
    return signed'(row[CoefW*k +: CoefW]);
  endfunction

endpackage

// ===== src/pmt_if.sv =====
// pmt_if: valid/ready channel interfaces for points, results and register writes
// depends on pmt_pkg
interface pmt_in_if;
  import pmt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] in_x;
  logic signed [CompW-1:0] in_y;
  logic signed [CompW-1:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface pmt_out_if;
  import pmt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] out_x;
  logic signed [CompW-1:0] out_y;
  logic signed [CompW-1:0] out_z;
  logic                    clipped;
  logic                    w_zero;
  modport source (output valid, out_x, out_y, out_z, clipped, w_zero, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, w_zero, output ready);
endinterface

interface pmt_cfg_if;
  import pmt_pkg::*;
  logic           valid;
  logic           ready;
  logic [2:0]     index;
  logic [63:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pmt_div.sv =====
// pmt_div: pipelined restoring divider, two quotient bits per stage
// depends on pmt_pkg; remainder must start below the divisor
module pmt_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pmt_pkg::RemW-1:0]     rem_in,
  input  logic [pmt_pkg::FracW-1:0]    nlo_in,
  input  logic [pmt_pkg::SumW-1:0]     den_in,
  output logic [pmt_pkg::QuotW-1:0]    quot
);
  import pmt_pkg::*;

  logic [RemW-1:0]  rem_r [DivStages];
  logic [QuotW-1:0] nb_r  [DivStages];
  logic [SumW-1:0]  den_r [DivStages];
  logic [QuotW-1:0] q_r   [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    logic [RemW-1:0]  rem_i, rem_nxt, t;
    logic [QuotW-1:0] nb_i, nb_nxt, q_i, q_nxt;
    logic [SumW-1:0]  den_i;

    if (s == 0) begin : g_first
      assign rem_i = rem_in;
      assign nb_i  = {nlo_in, {(QuotW-FracW){1'b0}}};
      assign den_i = den_in;
      assign q_i   = '0;
    end else begin : g_rest
      assign rem_i = rem_r[s-1];
      assign nb_i  = nb_r[s-1];
      assign den_i = den_r[s-1];
      assign q_i   = q_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_i;
      nb_nxt  = nb_i;
      q_nxt   = q_i;
      for (int i = 0; i < BitsPerStg; i++) begin
        t      = {rem_nxt[RemW-2:0], nb_nxt[QuotW-1]};
        nb_nxt = {nb_nxt[QuotW-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t     = t - {1'b0, den_i};
          q_nxt = {q_nxt[QuotW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QuotW-2:0], 1'b0};
        end
        rem_nxt = t;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nb_r[s]  <= nb_nxt;
        den_r[s] <= den_i;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign quot = q_r[DivStages-1];

endmodule

// ===== src/point_matrix_transform_unit.sv =====
// point_matrix_transform_unit: top level, 4x4 point transform with perspective divide
// depends on pmt_pkg, pmt_if and pmt_div
//
// usage:
//   in_ch carries one point (in_x, in_y, in_z, signed q16.16) per transfer.
//   out_ch returns one result per point, in order: out_x/y/z (q16.16),
//   clipped when any component saturated, w_zero when the projective kind
//   met w equal to zero and the sums were passed on undivided.
//   cfg_ch writes the four coefficient rows (index 0..3) and the transform
//   kind (index 4); other indexes are dropped. cfg_ch.ready is always high.
//   Write registers only while no point is in flight.
// throughput: one point per cycle, the pipeline takes a new point every
//   cycle while the output side keeps up.
// pipeline: 4 stages for input capture, multiply, sum and divide setup,
//   16 divider stages (two quotient bits each, three lanes in parallel)
//   and one output register.
// stall: when out valid is held without ready, the whole pipeline freezes
//   and in_ch.ready drops; nothing is lost or repeated.
// reset: rst_n low clears all valid bits and loads the identity matrix
//   with kind 3x3.
module point_matrix_transform_unit (
  input  logic      clk,
  input  logic      rst_n,
  pmt_in_if.sink    in_ch,
  pmt_out_if.source out_ch,
  pmt_cfg_if.sink   cfg_ch
);
  import pmt_pkg::*;

  logic [63:0] row_r [4];
  kind_t       kind_r;

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW0_RST;
      row_r[1] <= ROW1_RST;
      row_r[2] <= ROW2_RST;
      row_r[3] <= ROW3_RST;
      kind_r   <= KIND_3X3;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROW0: row_r[0] <= cfg_ch.data;
        REG_ROW1: row_r[1] <= cfg_ch.data;
        REG_ROW2: row_r[2] <= cfg_ch.data;
        REG_ROW3: row_r[3] <= cfg_ch.data;
        REG_KIND: kind_r   <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic [DivStages-1:0] vd_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_ch.valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vd_r        <= {vd_r[DivStages-2:0], v3_r};
      out_valid_r <= vd_r[DivStages-1];
    end
  end

  // stage 0: input capture
  logic signed [CompW-1:0] p_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= in_ch.in_x;
      p_r[1] <= in_ch.in_y;
      p_r[2] <= in_ch.in_z;
    end
  end

  // stage 1: twelve products, lane 3 is w
  logic signed [CoefW-1:0] m_c   [4][3];
  logic signed [CoefW-1:0] cst_c [4];
  logic signed [ProdW-1:0] prod_r [4][3];
  logic signed [CoefW-1:0] cst_r  [4];
  logic                    proj_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (kind_r == KIND_AFFINE) begin
        for (int j = 0; j < 3; j++) m_c[k][j] = coef(row_r[k], j);
        cst_c[k] = coef(row_r[k], 3);
      end else begin
        for (int j = 0; j < 3; j++) m_c[k][j] = coef(row_r[j], k);
        cst_c[k] = (kind_r == KIND_PROJ) ? coef(row_r[3], k) : '0;
      end
    end
    for (int j = 0; j < 3; j++) m_c[3][j] = coef(row_r[j], 3);
    cst_c[3] = coef(row_r[3], 3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) prod_r[k][j] <= p_r[j] * m_c[k][j];
        cst_r[k] <= cst_c[k];
      end
      proj_r <= (kind_r == KIND_PROJ);
    end
  end

  // stage 2: exact q.28 sums
  logic signed [SumW-1:0] sum_r [4];
  logic                   proj2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= SumW'(prod_r[k][0]) + SumW'(prod_r[k][1]) + SumW'(prod_r[k][2])
                  + (SumW'(cst_r[k]) <<< FracW);
      end
      proj2_r <= proj_r;
    end
  end

  // stage 3: rounding path and divider setup
  logic                    wz_c, use_div_c;
  logic [SumW-1:0]         ud_c;
  logic [SumW-1:0]         un_c   [3];
  logic signed [SumW-1:0]  t_c    [3];
  logic signed [SumW-13:0] q_c    [3];
  side_t                   side_c;
  side_t                   side_r [DivStages+1];
  logic [RemW-1:0]         rem0_r [3];
  logic [FracW-1:0]        nlo_r  [3];
  logic [SumW-1:0]         den_r;

  always_comb begin
    wz_c      = proj2_r && (sum_r[3] == '0);
    use_div_c = proj2_r && !wz_c;
    ud_c      = sum_r[3][SumW-1] ? SumW'(-sum_r[3]) : SumW'(sum_r[3]);
    side_c.wz      = wz_c;
    side_c.use_div = use_div_c;
    for (int k = 0; k < 3; k++) begin
      un_c[k] = sum_r[k][SumW-1] ? SumW'(-sum_r[k]) : SumW'(sum_r[k]);
      t_c[k]  = sum_r[k] + SumW'(2048);
      q_c[k]  = t_c[k][SumW-1:12];
      // round half up, then clamp to 32 bits
      if (!q_c[k][SumW-13] && (q_c[k][SumW-14:CompW-1] != '0)) begin
        side_c.lane[k].rnd   = {1'b0, {(CompW-1){1'b1}}};
        side_c.lane[k].rclip = 1'b1;
      end else if (q_c[k][SumW-13] && (q_c[k][SumW-14:CompW-1] != '1)) begin
        side_c.lane[k].rnd   = {1'b1, {(CompW-1){1'b0}}};
        side_c.lane[k].rclip = 1'b1;
      end else begin
        side_c.lane[k].rnd   = q_c[k][CompW-1:0];
        side_c.lane[k].rclip = 1'b0;
      end
      side_c.lane[k].neg = sum_r[k][SumW-1] ^ sum_r[3][SumW-1];
      // integer part of the quotient would reach 2^16
      side_c.lane[k].ovf = {{FracW{1'b0}}, un_c[k]} >= {ud_c, {FracW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_c;
      den_r     <= ud_c;
      for (int k = 0; k < 3; k++) begin
        // an overflowing lane divides garbage, its quotient is replaced later
        rem0_r[k] <= side_c.lane[k].ovf ? '0 : RemW'(un_c[k] >> FracW);
        nlo_r[k]  <= un_c[k][FracW-1:0];
      end
      for (int s = 1; s <= DivStages; s++) side_r[s] <= side_r[s-1];
    end
  end

  // divider lanes
  logic [QuotW-1:0] mag [3];
  for (genvar k = 0; k < 3; k++) begin : g_lane
    pmt_div u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (rem0_r[k]),
      .nlo_in (nlo_r[k]),
      .den_in (den_r),
      .quot   (mag[k])
    );
  end

  // output stage
  side_t                   fs;
  logic signed [CompW-1:0] res_c [3];
  logic [2:0]              clip_c;
  logic signed [CompW-1:0] res_r [3];
  logic                    clipped_r, w_zero_r;

  // side data lines up with the last divider stage
  assign fs = side_r[DivStages];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!fs.use_div) begin
        res_c[k]  = fs.lane[k].rnd;
        clip_c[k] = fs.lane[k].rclip;
      end else if (fs.lane[k].ovf) begin
        res_c[k]  = fs.lane[k].neg ? {1'b1, {(CompW-1){1'b0}}} : {1'b0, {(CompW-1){1'b1}}};
        clip_c[k] = 1'b1;
      end else if (fs.lane[k].neg) begin
        clip_c[k] = mag[k] > {1'b1, {(QuotW-1){1'b0}}};
        res_c[k]  = clip_c[k] ? {1'b1, {(CompW-1){1'b0}}} : CompW'(-mag[k]);
      end else begin
        clip_c[k] = mag[k][QuotW-1];
        res_c[k]  = clip_c[k] ? {1'b0, {(CompW-1){1'b1}}} : CompW'(mag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) res_r[k] <= res_c[k];
      clipped_r <= |clip_c;
      w_zero_r  <= fs.wz;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_x   = res_r[0];
  assign out_ch.out_y   = res_r[1];
  assign out_ch.out_z   = res_r[2];
  assign out_ch.clipped = clipped_r;
  assign out_ch.w_zero  = w_zero_r;

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input blocked without an output stall");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vd_r) && $stable(v3_r) && $stable(v0_r)))
    else $error("pipeline moved during a stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (vd_r == '0)))
    else $error("valid bits not cleared by reset");

endmodule

// ===== dv/pmt_checker.sv =====
`timescale 1ns / 100ps
// pmt_checker: watches the point, result and register channels, predicts each
// transformed point and compares it with the block's output; depends on pmt_pkg, pmt_if
module pmt_checker
  import pmt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pmt_in_if    in_ch,
  pmt_out_if   out_ch,
  pmt_cfg_if   cfg_ch,
  output int   fail_cnt,
  output int   pending_cnt
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clip;
    logic        wz;
  } point_res_t;

  logic [63:0] rows [4];
  kind_t       kind;
  point_res_t  expected_pts [$];

  function automatic longint coef_of(int r, int k);
    logic signed [15:0] c;
    c = rows[r][16*k +: 16];
    return longint'(c);
  endfunction

  function automatic longint sat32(longint v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // q.28 to q16.16, half rounds up
  function automatic longint round_q28(longint s, inout logic clip);
    return sat32((s + 2048) >>> 12, clip);
  endfunction

  function automatic longint div_q(longint n, longint d, inout logic clip);
    logic neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    if (un / ud >= 65536) begin
      clip = 1'b1;
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    // exact since un < 2^52 and shift keeps it under 2^68? use 128-bit
    q = longint'((128'(un) << 16) / 128'(ud));
    if (neg) begin
      if (q > 64'sd2147483648) begin
        clip = 1'b1;
        return -64'sd2147483648;
      end
      return -q;
    end
    return sat32(q, clip);
  endfunction

  function automatic point_res_t transform_point(logic [31:0] ix, logic [31:0] iy,
                                                 logic [31:0] iz);
    point_res_t r;
    longint p [3];
    longint s [3];
    longint o [3];
    longint w;
    logic clip, wz;
    p[0] = longint'($signed(ix));
    p[1] = longint'($signed(iy));
    p[2] = longint'($signed(iz));
    clip = 1'b0;
    wz = 1'b0;
    w = 0;
    for (int k = 0; k < 3; k++) begin
      if (kind == KIND_AFFINE)
        s[k] = p[0]*coef_of(k,0) + p[1]*coef_of(k,1) + p[2]*coef_of(k,2)
             + coef_of(k,3)*65536;
      else
        s[k] = p[0]*coef_of(0,k) + p[1]*coef_of(1,k) + p[2]*coef_of(2,k);
      if (kind == KIND_PROJ) s[k] += coef_of(3,k)*65536;
    end
    if (kind == KIND_PROJ) begin
      w = p[0]*coef_of(0,3) + p[1]*coef_of(1,3) + p[2]*coef_of(2,3) + coef_of(3,3)*65536;
      wz = (w == 0);
    end
    for (int k = 0; k < 3; k++) begin
      if (kind == KIND_PROJ && !wz) o[k] = div_q(s[k], w, clip);
      else o[k] = round_q28(s[k], clip);
    end
    r.x = o[0][31:0];
    r.y = o[1][31:0];
    r.z = o[2][31:0];
    r.clip = clip;
    r.wz = wz;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  initial fail_cnt = 0;
  assign pending_cnt = expected_pts.size();

  always @(posedge clk) begin
    point_res_t e;
    if (!rst_n) begin
      rows[0] <= ROW0_RST;
      rows[1] <= ROW1_RST;
      rows[2] <= ROW2_RST;
      rows[3] <= ROW3_RST;
      kind <= KIND_3X3;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index < REG_KIND) rows[cfg_ch.index[1:0]] <= cfg_ch.data;
        else if (cfg_ch.index == REG_KIND) kind <= cfg_ch.data[1:0];
      end
      if (in_ch.valid && in_ch.ready)
        expected_pts.push_back(transform_point(in_ch.in_x, in_ch.in_y, in_ch.in_z));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          $display("unexpected result transfer at %0t", $time);
          fail_cnt++;
        end else begin
          e = expected_pts.pop_front();
          if (out_ch.out_x !== e.x) report_mismatch("out_x", out_ch.out_x, e.x);
          if (out_ch.out_y !== e.y) report_mismatch("out_y", out_ch.out_y, e.y);
          if (out_ch.out_z !== e.z) report_mismatch("out_z", out_ch.out_z, e.z);
          if (out_ch.clipped !== e.clip)
            report_mismatch("clipped", 32'(out_ch.clipped), 32'(e.clip));
          if (out_ch.w_zero !== e.wz)
            report_mismatch("w_zero", 32'(out_ch.w_zero), 32'(e.wz));
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for point_matrix_transform_unit
// depends on pmt_pkg, pmt_if and pmt_checker
module tb;
  import pmt_pkg::*;

  localparam int LATENCY   = 21;
  localparam int CYCLE_CAP = 400000;
  // indexes past the register file, writes there are dropped
  localparam reg_idx_t REG_SPARE_LO = 3'd5;
  localparam reg_idx_t REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_cnt, pending_cnt;
  int   cycle_cnt = 0;
  logic hold_off = 1'b0;
  logic calm = 1'b0;

  pmt_in_if  in_ch ();
  pmt_out_if out_ch ();
  pmt_cfg_if cfg_ch ();

  point_matrix_transform_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pmt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_cnt(fail_cnt), .pending_cnt(pending_cnt)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[point_matrix_transform_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
  end

  function automatic logic [31:0] pick_comp();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return $signed($urandom_range(32'h7_ffff)) - 32'sh4_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hffff;
      5: return 16'($urandom);
      default: return 16'($signed($urandom_range(16'h1fff)) - 16'sh1000);
    endcase
  endfunction

  // leaves valid high on return, the next call drives it anew and a drain takes it down
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x <= x;
    in_ch.in_y <= y;
    in_ch.in_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // leaves valid high on return, the caller takes it down after the last write
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load_matrix(kind_t k, logic [63:0] r0, logic [63:0] r1,
                             logic [63:0] r2, logic [63:0] r3);
    drain_results();
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_ROW3, r3);
    write_reg(REG_KIND, 64'(k));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_row();
    return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
  endfunction

  initial begin
    logic [63:0] w_row;
    in_ch.valid = 1'b0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // identity at reset, field extremes
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0800);
    // saturation on sums
    load_matrix(KIND_3X3, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 64'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0001, 32'h0, 32'h0);
    // unused kind value acts as 3x3
    drain_results();
    write_reg(REG_KIND, 64'd3);
    cfg_ch.valid <= 1'b0;
    send_point(32'h0003_0000, 32'hfffe_0000, 32'h1234_5678);
    // affine with translation extremes
    load_matrix(KIND_AFFINE, 64'h8000_0000_0000_1000, 64'h7fff_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    // projective: w zero, divide by w, quotient overflow
    load_matrix(KIND_PROJ, 64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h0000_0000_0000_0000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    load_matrix(KIND_PROJ, 64'h1000_0000_0000_1000, 64'h0000_0000_1000_0000,
                64'h0000_1000_0000_0000, 64'h0000_0000_0000_0000);
    send_point(32'h0002_0000, 32'h0005_0000, 32'hfff9_0000);
    send_point(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'h0001_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    // extra register index is dropped
    drain_results();
    write_reg(REG_SPARE_HI, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_SPARE_LO, 64'h0);
    cfg_ch.valid <= 1'b0;
    send_point(32'h0004_0000, 32'h0001_0000, 32'h0001_0000);

    // random phases across kinds, every third one with the w constant set to 1.0
    for (int ph = 0; ph < 13; ph++) begin
      w_row = {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
      load_matrix(kind_t'(ph % 4), rand_row(), rand_row(), rand_row(),
                  (ph % 3 == 0) ? {16'h1000, w_row[47:0]} : rand_row());
      calm = (ph == 5);
      if (ph == 8) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (120) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 48; i++) begin
        send_point(pick_comp(), pick_comp(), pick_comp());
        if (ph == 10 && i == 20) drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    if (fail_cnt == 0) begin
      $display("[point_matrix_transform_unit] OK");
    end else begin
      $display("[point_matrix_transform_unit] ERROR");
    end
    $finish;
  end

endmodule
